@@ src/ffra_pkg.sv @@
package ffra_pkg;

   localparam int COUNT_W = 30;
   localparam int SEAT_W  = 20;
   localparam int NROW_W  = 11;
   localparam int MAXR_W  = 10;
   localparam int CMPR_W  = 17;
   localparam int TOTAL_W = 31;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SEATS_PER_ROW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE   = 2'd1;

   localparam logic KIND_CONTIG = 1'b0;
   localparam logic KIND_SPREAD = 1'b1;

   typedef struct packed {
      logic clear;
      logic load;
      logic eval_contig;
      logic eval_sum;
      logic eval_fill;
      logic next_row;
      logic rewind;
      logic grant;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic spread;
      logic zero_count;
      logic fit;
      logic sum_ok;
      logic need_done;
      logic last;
      logic clear_last;
   } status_type;

endpackage

@@ src/ffra_datapath.sv @@
module ffra_datapath import ffra_pkg::*; #(
   parameter int ROWS = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic                    req_kind,
   input  logic [COUNT_W-1:0]      req_count,
   input  logic [MAXR_W-1:0]       req_max_row,
   input  logic                    csr_valid,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [SEAT_W-1:0]       csr_data,
   output logic                    rsp_granted,
   output logic [MAXR_W-1:0]       rsp_row,
   output logic [SEAT_W-1:0]       rsp_column
);

   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [SEAT_W-1:0] used_mem [ROWS];
   logic [SEAT_W-1:0] rd_used_ff;

   logic [SEAT_W-1:0]  seats_ff;
   logic [NROW_W-1:0]  nrows_cfg_ff;
   logic [RW-1:0]      row_ff, row_in;
   logic [RW-1:0]      lim_ff;
   logic               kind_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] need_ff, need_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               res_granted_ff;
   logic [MAXR_W-1:0]  res_row_ff;
   logic [SEAT_W-1:0]  res_col_ff;
   logic               out_granted_ff;
   logic [MAXR_W-1:0]  out_row_ff;
   logic [SEAT_W-1:0]  out_col_ff;

   logic [CMPR_W-1:0]  nrows_eff;
   logic [CMPR_W-1:0]  max_ext;
   logic [RW-1:0]      lim_in;
   logic [SEAT_W-1:0]  free_units;
   logic [SEAT_W-1:0]  take;
   logic               fit;
   logic               we;
   logic [SEAT_W-1:0]  wdata;

   // clamp the limit row to the managed rows
   always_comb begin
      if (nrows_cfg_ff == '0) begin
         nrows_eff = CMPR_W'(1);
      end else if (CMPR_W'(nrows_cfg_ff) > CMPR_W'(ROWS)) begin
         nrows_eff = CMPR_W'(ROWS);
      end else begin
         nrows_eff = CMPR_W'(nrows_cfg_ff);
      end
      max_ext = CMPR_W'(req_max_row);
      if (max_ext > nrows_eff - CMPR_W'(1)) begin
         lim_in = RW'(nrows_eff - CMPR_W'(1));
      end else begin
         lim_in = RW'(max_ext);
      end
   end

   always_comb begin
      free_units = (rd_used_ff >= seats_ff) ? '0 : seats_ff - rd_used_ff;
      fit = (free_units != '0) && (COUNT_W'(free_units) >= count_ff);
      take = (COUNT_W'(free_units) < need_ff) ? free_units : need_ff[SEAT_W-1:0];
      total_in = total_ff + TOTAL_W'(free_units);
      need_in = need_ff - COUNT_W'(take);
   end

   always_comb begin
      we = 1'b0;
      wdata = '0;
      if (cmd.clear) begin
         we = 1'b1;
      end else if (cmd.eval_contig && fit && count_ff != '0) begin
         we = 1'b1;
         wdata = rd_used_ff + count_ff[SEAT_W-1:0];
      end else if (cmd.eval_fill) begin
         we = 1'b1;
         wdata = rd_used_ff + take;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         used_mem[row_ff] <= wdata;
      end
      rd_used_ff <= used_mem[row_ff];
   end

   always_comb begin
      row_in = row_ff;
      if (cmd.load || cmd.rewind) begin
         row_in = '0;
      end else if (cmd.clear || cmd.next_row) begin
         row_in = row_ff + RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         seats_ff <= 20'hFFFFF;
         nrows_cfg_ff <= 11'd1024;
      end else begin
         row_ff <= row_in;
         if (csr_valid && csr_index == CSR_SEATS_PER_ROW) begin
            seats_ff <= csr_data;
         end
         if (csr_valid && csr_index == CSR_ROWS_IN_USE) begin
            nrows_cfg_ff <= csr_data[NROW_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         count_ff <= req_count;
         need_ff <= req_count;
         total_ff <= '0;
         lim_ff <= lim_in;
         res_granted_ff <= 1'b0;
         res_row_ff <= '0;
         res_col_ff <= '0;
      end else begin
         if (cmd.eval_sum) begin
            total_ff <= total_in;
         end
         if (cmd.eval_fill) begin
            need_ff <= need_in;
         end
         if (cmd.eval_contig && fit) begin
            res_granted_ff <= 1'b1;
            res_row_ff <= MAXR_W'(row_ff);
            res_col_ff <= rd_used_ff;
         end
         if (cmd.grant) begin
            res_granted_ff <= 1'b1;
         end
      end
      if (cmd.out_load) begin
         out_granted_ff <= res_granted_ff;
         out_row_ff <= res_row_ff;
         out_col_ff <= res_col_ff;
      end
   end

   always_comb begin
      status.spread = (kind_ff == KIND_SPREAD);
      status.zero_count = (count_ff == '0);
      status.fit = fit;
      status.sum_ok = (total_in >= TOTAL_W'(count_ff));
      status.need_done = (need_in == '0);
      status.last = (row_ff == lim_ff);
      status.clear_last = (row_ff == RW'(ROWS - 1));
   end

   assign rsp_granted = out_granted_ff;
   assign rsp_row = out_row_ff;
   assign rsp_column = out_col_ff;

endmodule

@@ src/ffra_ctrl.sv @@
module ffra_ctrl import ffra_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_EVAL   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   localparam logic [1:0] MODE_CONTIG = 2'd0;
   localparam logic [1:0] MODE_SUM    = 2'd1;
   localparam logic [1:0] MODE_FILL   = 2'd2;

   logic [2:0] state_ff, state_in;
   logic [1:0] mode_ff, mode_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
               mode_in = MODE_CONTIG;
            end
         end
         ST_READ: begin
            if (mode_ff == MODE_CONTIG && status.spread) begin
               mode_in = MODE_SUM;
            end
            // empty spread request: grant with no scan
            if (status.spread && status.zero_count) begin
               cmd.grant = 1'b1;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_READ;
            unique case (mode_ff)
               MODE_SUM: begin
                  cmd.eval_sum = 1'b1;
                  if (status.sum_ok) begin
                     cmd.rewind = 1'b1;
                     mode_in = MODE_FILL;
                  end else if (status.last) begin
                     state_in = ST_FINISH;
                  end else begin
                     cmd.next_row = 1'b1;
                  end
               end
               MODE_FILL: begin
                  cmd.eval_fill = 1'b1;
                  if (status.need_done || status.last) begin
                     cmd.grant = 1'b1;
                     state_in = ST_FINISH;
                  end else begin
                     cmd.next_row = 1'b1;
                  end
               end
               default: begin
                  cmd.eval_contig = 1'b1;
                  if (status.fit || status.last) begin
                     state_in = ST_FINISH;
                  end else begin
                     cmd.next_row = 1'b1;
                  end
               end
            endcase
         end
         ST_FINISH: begin
            // hold until the output word is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         mode_ff <= MODE_CONTIG;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ src/first_fit_row_allocator.sv @@
// Row allocator with first-fit placement. After reset the occupancy table is
// cleared row by row, during which no request word is taken (register
// writes are). A contiguous request scans rows from 0 to the first row that
// fits or the limit row; a spread request scans once to add up free space
// and, when it suffices, a second time from row 0 to fill rows. The single
// occupancy table is read one row at a time with a registered read. A
// finished result waits in an output register while the next request is
// taken.
module first_fit_row_allocator import ffra_pkg::*; #(
   parameter int ROWS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic [COUNT_W-1:0]   req_count,
   input  logic [MAXR_W-1:0]    req_max_row,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_granted,
   output logic [MAXR_W-1:0]    rsp_row,
   output logic [SEAT_W-1:0]    rsp_column,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SEAT_W-1:0]    csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   ffra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ffra_datapath #(.ROWS(ROWS)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_kind    (req_kind),
      .req_count   (req_count),
      .req_max_row (req_max_row),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_granted (rsp_granted),
      .rsp_row     (rsp_row),
      .rsp_column  (rsp_column)
   );

endmodule

@@ tb/sv/ffra_checker.sv @@
`timescale 1ns / 100ps
module ffra_checker import ffra_pkg::*; #(
   parameter int ROWS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_kind,
   input  logic [COUNT_W-1:0]   req_count,
   input  logic [MAXR_W-1:0]    req_max_row,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 rsp_granted,
   input  logic [MAXR_W-1:0]    rsp_row,
   input  logic [SEAT_W-1:0]    rsp_column,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SEAT_W-1:0]    csr_data,
   output int                   errors,
   output int                   pending
);

   typedef struct packed {
      logic              granted;
      logic [MAXR_W-1:0] row;
      logic [SEAT_W-1:0] column;
   } grant_type;

   longint unsigned occupancy[ROWS];
   logic [SEAT_W-1:0] seats;
   logic [NROW_W-1:0] rows_used;
   grant_type grants_due[$];

   function automatic longint unsigned space_left(int r);
      return (occupancy[r] >= seats) ? 0 : seats - occupancy[r];
   endfunction

   function automatic grant_type allocate(logic kind, longint unsigned count,
                                          longint unsigned max_row);
      grant_type g;
      longint unsigned nrows, lim, total, need, f, take;
      g = '0;
      nrows = rows_used;
      if (nrows == 0) nrows = 1;
      if (nrows > ROWS) nrows = ROWS;
      lim = (max_row > nrows - 1) ? nrows - 1 : max_row;
      if (kind == KIND_CONTIG) begin
         for (int r = 0; r <= lim; r++) begin
            f = space_left(r);
            if (f > 0 && count <= f) begin
               g.granted = 1'b1;
               g.row = MAXR_W'(r);
               g.column = SEAT_W'(occupancy[r]);
               occupancy[r] += count;
               return g;
            end
         end
         return g;
      end
      total = 0;
      for (int r = 0; r <= lim && total < count; r++) total += space_left(r);
      if (total < count) return g;
      need = count;
      for (int r = 0; r <= lim && need > 0; r++) begin
         f = space_left(r);
         take = (f < need) ? f : need;
         occupancy[r] += take;
         need -= take;
      end
      g.granted = 1'b1;
      return g;
   endfunction

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         foreach (occupancy[r]) occupancy[r] = 0;
         seats = '1;
         rows_used = 11'd1024;
         grants_due.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SEATS_PER_ROW) seats = csr_data;
            else if (csr_index == CSR_ROWS_IN_USE) rows_used = csr_data[NROW_W-1:0];
         end
         if (req_valid && req_ready)
            grants_due.push_back(allocate(req_kind, req_count, req_max_row));
         if (rsp_valid && rsp_ready) begin
            if (grants_due.size() == 0) begin
               $display("%0t: unexpected result word granted=%0d row=%0d column=%0d",
                        $time, rsp_granted, rsp_row, rsp_column);
               errors++;
            end else begin
               want = grants_due.pop_front();
               if (rsp_granted !== want.granted) begin
                  $display("%0t: granted expected %0d actual %0d",
                           $time, want.granted, rsp_granted);
                  errors++;
               end
               if (rsp_row !== want.row) begin
                  $display("%0t: row expected %0d actual %0d", $time, want.row, rsp_row);
                  errors++;
               end
               if (rsp_column !== want.column) begin
                  $display("%0t: column expected %0d actual %0d",
                           $time, want.column, rsp_column);
                  errors++;
               end
            end
         end
      end
      pending = grants_due.size();
   end

endmodule

@@ tb/sv/tb_first_fit_row_allocator.sv @@
`timescale 1ns / 100ps
module tb_first_fit_row_allocator import ffra_pkg::*;;

   localparam int ROWS = 1024;
   localparam int CYCLE_LIMIT = 20000000;

   logic                 clock, reset;
   logic                 req_valid, req_ready, req_kind;
   logic [COUNT_W-1:0]   req_count;
   logic [MAXR_W-1:0]    req_max_row;
   logic                 rsp_valid, rsp_granted;
   logic                 rsp_ready = 1'b0;
   logic [MAXR_W-1:0]    rsp_row;
   logic [SEAT_W-1:0]    rsp_column;
   logic                 csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SEAT_W-1:0]    csr_data;
   int errors, pending, sent;
   int cycles = 0;
   int send_idle = 30;
   int recv_idle = 75;
   logic [SEAT_W-1:0] seats;

   first_fit_row_allocator #(.ROWS(ROWS)) dut (.*);
   ffra_checker #(.ROWS(ROWS)) checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_ready <= ($urandom_range(99) >= recv_idle);
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // pick the idling mix from how far the stimulus has come
   always @(posedge clock) begin
      if (sent < 200) begin
         send_idle <= 30; recv_idle <= 75;
      end else if (sent < 400) begin
         send_idle <= 75; recv_idle <= 30;
      end else begin
         send_idle <= 0; recv_idle <= 0;
      end
   end

   task automatic send(logic kind, logic [COUNT_W-1:0] count, logic [MAXR_W-1:0] max_row);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_count <= count;
      req_max_row <= max_row;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [SEAT_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0 || rsp_valid) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SEATS_PER_ROW) seats = value;
   endtask

   task automatic random_burst(int n, int row_span);
      logic [COUNT_W-1:0] count;
      logic [MAXR_W-1:0] max_row;
      repeat (n) begin
         case ($urandom_range(9))
            0:       count = '0;
            1:       count = '1;
            2:       count = COUNT_W'($urandom());
            3, 4:    count = COUNT_W'($urandom_range(seats * 3, 1));
            default: count = COUNT_W'($urandom_range(seats, 1));
         endcase
         max_row = ($urandom_range(4) == 0) ? MAXR_W'($urandom())
                                            : MAXR_W'($urandom_range(row_span));
         send(1'($urandom_range(1)), count, max_row);
      end
   endtask

   initial begin
      reset = 1; req_valid = 0; req_kind = 0; req_count = 0; req_max_row = 0;
      csr_valid = 0; csr_index = CSR_SEATS_PER_ROW; csr_data = 0;
      sent = 0; seats = '1;
      repeat (7) @(posedge clock);
      reset <= 0;
      // reset setting: full width rows, all rows managed
      send(KIND_CONTIG, 0, 0);
      send(KIND_CONTIG, 30'd1048575, 0);
      send(KIND_CONTIG, 1, 0);
      send(KIND_CONTIG, 1, 10'd1023);
      send(KIND_SPREAD, 0, 10'd1023);
      send(KIND_SPREAD, '1, 10'd1023);
      send(KIND_CONTIG, '1, 10'd1023);
      send(KIND_SPREAD, 5, 3);
      send(KIND_CONTIG, 0, 3);
      send(KIND_SPREAD, 30'd1048577, 2);
      send(KIND_CONTIG, 30'h2AAAAAAA, 10'h2AA);
      send(KIND_SPREAD, 30'h15555555, 10'h155);
      // shrink rows so earlier fills count as full, clamp the limit row
      write_reg(CSR_SEATS_PER_ROW, 4);
      write_reg(CSR_ROWS_IN_USE, 0);
      send(KIND_CONTIG, 0, 10'd1023);
      send(KIND_SPREAD, 1, 10'd1023);
      write_reg(CSR_ROWS_IN_USE, 20'd2047);
      send(KIND_CONTIG, 4, 10'd1023);
      send(KIND_SPREAD, 9, 10'd1023);
      send(KIND_CONTIG, 0, 10'd1023);
      write_reg(CSR_SEATS_PER_ROW, 8);
      write_reg(CSR_ROWS_IN_USE, 16);
      random_burst(90, 20);
      write_reg(CSR_SEATS_PER_ROW, 3);
      random_burst(60, 20);
      write_reg(CSR_SEATS_PER_ROW, 1000);
      write_reg(CSR_ROWS_IN_USE, 40);
      random_burst(120, 48);
      write_reg(CSR_SEATS_PER_ROW, 1);
      write_reg(CSR_ROWS_IN_USE, 1);
      random_burst(40, 4);
      write_reg(CSR_SEATS_PER_ROW, 20'd1048575);
      write_reg(CSR_ROWS_IN_USE, 1024);
      random_burst(60, 40);
      write_reg(CSR_SEATS_PER_ROW, 50000);
      write_reg(CSR_ROWS_IN_USE, 12);
      random_burst(160, 16);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ files.f @@
src/ffra_pkg.sv
src/ffra_datapath.sv
src/ffra_ctrl.sv
src/first_fit_row_allocator.sv
tb/sv/ffra_checker.sv
tb/sv/tb_first_fit_row_allocator.sv
